// ===== hw/rtl/lps_pkg.sv =====
package lps_pkg;

   localparam int CLIP_BITS = 11;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_WIDTH = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_HEIGHT = 4'd1;

   localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RESET = 11'd800;
   localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RESET = 11'd600;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   typedef struct packed {
      logic emit;
      logic in_window;
      logic last;
   } pixel_flags_type;

endpackage

// ===== hw/rtl/lps_line_core.sv =====
module lps_line_core #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lps_pkg::CLIP_BITS-1:0] clip_width,
   input  logic [lps_pkg::CLIP_BITS-1:0] clip_height,
   input  logic                          advance,
   input  logic                          mode,
   input  logic signed [COORD_BITS-1:0]  start_x,
   input  logic signed [COORD_BITS-1:0]  start_y,
   input  logic signed [COORD_BITS-1:0]  end_x_in,
   input  logic signed [COORD_BITS-1:0]  end_y_in,
   output logic signed [COORD_BITS-1:0]  pixel_x,
   output logic signed [COORD_BITS-1:0]  pixel_y,
   output lps_pkg::pixel_flags_type      flags
);

   localparam int ERR_BITS = COORD_BITS + 2;
   localparam int CMP_BITS =
      ((COORD_BITS > lps_pkg::CLIP_BITS) ? COORD_BITS : lps_pkg::CLIP_BITS) + 1;

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0] goal_x_ff, goal_x_in;
   logic signed [COORD_BITS-1:0] goal_y_ff, goal_y_in;
   logic [COORD_BITS-1:0]        delta_x_ff, delta_x_in;
   logic [COORD_BITS-1:0]        delta_y_ff, delta_y_in;
   logic                         step_x_neg_ff, step_x_neg_in;
   logic                         step_y_neg_ff, step_y_neg_in;
   logic signed [ERR_BITS-1:0]   error_ff, error_in;
   logic                         active_ff, active_in;

   logic signed [COORD_BITS:0]   diff_x, diff_y;
   logic signed [COORD_BITS:0]   mag_x, mag_y;
   logic                         load_x_neg, load_y_neg;
   logic [COORD_BITS-1:0]        load_dx, load_dy;
   logic signed [ERR_BITS:0]     e2, neg_dy, pos_dx;
   logic                         move_x, move_y;
   logic                         in_window, is_last;
   logic [CMP_BITS-1:0]          cmp_x, cmp_y, cmp_w, cmp_h;
   logic [COORD_BITS-1:0]        unit_x, unit_y;

   // endpoint setup on load
   always_comb begin
      diff_x = $signed({end_x_in[COORD_BITS-1], end_x_in})
             - $signed({start_x[COORD_BITS-1], start_x});
      diff_y = $signed({end_y_in[COORD_BITS-1], end_y_in})
             - $signed({start_y[COORD_BITS-1], start_y});
      load_x_neg = diff_x[COORD_BITS] || (diff_x == '0);
      load_y_neg = diff_y[COORD_BITS] || (diff_y == '0);
      mag_x = diff_x[COORD_BITS] ? -diff_x : diff_x;
      mag_y = diff_y[COORD_BITS] ? -diff_y : diff_y;
      load_dx = mag_x[COORD_BITS-1:0];
      load_dy = mag_y[COORD_BITS-1:0];
   end

   // current pixel and one error step
   always_comb begin
      cmp_x = {{(CMP_BITS-COORD_BITS){1'b0}}, cur_x_ff};
      cmp_y = {{(CMP_BITS-COORD_BITS){1'b0}}, cur_y_ff};
      cmp_w = {{(CMP_BITS-lps_pkg::CLIP_BITS){1'b0}}, clip_width};
      cmp_h = {{(CMP_BITS-lps_pkg::CLIP_BITS){1'b0}}, clip_height};
      in_window = !cur_x_ff[COORD_BITS-1] && (cmp_x < cmp_w)
               && !cur_y_ff[COORD_BITS-1] && (cmp_y < cmp_h);
      is_last = (cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff);

      e2 = $signed({error_ff, 1'b0});
      neg_dy = -$signed({3'b000, delta_y_ff});
      pos_dx = $signed({3'b000, delta_x_ff});
      move_x = e2 > neg_dy;
      move_y = e2 < pos_dx;
      unit_x = step_x_neg_ff ? {COORD_BITS{1'b1}} : {{(COORD_BITS-1){1'b0}}, 1'b1};
      unit_y = step_y_neg_ff ? {COORD_BITS{1'b1}} : {{(COORD_BITS-1){1'b0}}, 1'b1};
   end

   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      goal_x_in     = goal_x_ff;
      goal_y_in     = goal_y_ff;
      delta_x_in    = delta_x_ff;
      delta_y_in    = delta_y_ff;
      step_x_neg_in = step_x_neg_ff;
      step_y_neg_in = step_y_neg_ff;
      error_in      = error_ff;
      active_in     = active_ff;
      if (advance) begin
         if (mode == lps_pkg::MODE_LOAD) begin
            cur_x_in      = start_x;
            cur_y_in      = start_y;
            goal_x_in     = end_x_in;
            goal_y_in     = end_y_in;
            delta_x_in    = load_dx;
            delta_y_in    = load_dy;
            step_x_neg_in = load_x_neg;
            step_y_neg_in = load_y_neg;
            error_in      = $signed({2'b00, load_dx}) - $signed({2'b00, load_dy});
            active_in     = 1'b1;
         end else if (active_ff) begin
            if (is_last) begin
               active_in = 1'b0;
            end else begin
               error_in = error_ff
                        - (move_x ? $signed({2'b00, delta_y_ff}) : '0)
                        + (move_y ? $signed({2'b00, delta_x_ff}) : '0);
               if (move_x) begin
                  cur_x_in = cur_x_ff + $signed(unit_x);
               end
               if (move_y) begin
                  cur_y_in = cur_y_ff + $signed(unit_y);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         goal_x_ff     <= '0;
         goal_y_ff     <= '0;
         delta_x_ff    <= '0;
         delta_y_ff    <= '0;
         step_x_neg_ff <= 1'b0;
         step_y_neg_ff <= 1'b0;
         error_ff      <= '0;
         active_ff     <= 1'b0;
      end else begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         goal_x_ff     <= goal_x_in;
         goal_y_ff     <= goal_y_in;
         delta_x_ff    <= delta_x_in;
         delta_y_ff    <= delta_y_in;
         step_x_neg_ff <= step_x_neg_in;
         step_y_neg_ff <= step_y_neg_in;
         error_ff      <= error_in;
         active_ff     <= active_in;
      end
   end

   assign pixel_x         = cur_x_ff;
   assign pixel_y         = cur_y_ff;
   assign flags.emit      = (mode == lps_pkg::MODE_STEP) && active_ff;
   assign flags.in_window = in_window;
   assign flags.last      = is_last;

endmodule

// ===== hw/rtl/line_pixel_stepper_top.sv =====
// path: a step request is registered in the input stage, and its pixel then in the
// output register that drives rsp_
// throughput: one request per cycle, loads and steps alike, unless a pixel waits
// on a stalled rsp_ channel; the line core registers each error and position update
// reset: synchronous, active high; clears both channel valids and the line,
// and sets the clip window to 800 by 600
module line_pixel_stepper_top #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,  // start_x, start_y, end_x_in, end_y_in
   input  logic                              req_tuser,  // mode
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,  // pixel_x, pixel_y
   output logic                              rsp_tuser,  // inside_res
   output logic                              rsp_tlast,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lps_pkg::CLIP_BITS-1:0]     csr_data
);

   localparam int RSP_BITS = ((2*COORD_BITS+7)/8)*8;

   logic [lps_pkg::CLIP_BITS-1:0] clip_width_ff, clip_height_ff;

   logic                         in_valid_ff;
   logic                         in_mode_ff;
   logic signed [COORD_BITS-1:0] in_x0_ff, in_y0_ff, in_x1_ff, in_y1_ff;

   logic                         out_valid_ff, out_valid_in;
   logic signed [COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic                         out_inside_ff, out_last_ff;

   logic                         advance;
   logic signed [COORD_BITS-1:0] pix_x, pix_y;
   lps_pkg::pixel_flags_type     flags;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_width_ff  <= lps_pkg::CLIP_WIDTH_RESET;
         clip_height_ff <= lps_pkg::CLIP_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lps_pkg::CSR_CLIP_WIDTH:  clip_width_ff  <= csr_data;
            lps_pkg::CSR_CLIP_HEIGHT: clip_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // held item moves on unless its pixel has nowhere to go
   assign advance    = in_valid_ff && (!flags.emit || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff <= req_tuser;
         in_x0_ff   <= req_tdata[COORD_BITS-1:0];
         in_y0_ff   <= req_tdata[2*COORD_BITS-1:COORD_BITS];
         in_x1_ff   <= req_tdata[3*COORD_BITS-1:2*COORD_BITS];
         in_y1_ff   <= req_tdata[4*COORD_BITS-1:3*COORD_BITS];
      end
   end

   lps_line_core #(
      .COORD_BITS(COORD_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .clip_width  (clip_width_ff),
      .clip_height (clip_height_ff),
      .advance     (advance),
      .mode        (in_mode_ff),
      .start_x     (in_x0_ff),
      .start_y     (in_y0_ff),
      .end_x_in    (in_x1_ff),
      .end_y_in    (in_y1_ff),
      .pixel_x     (pix_x),
      .pixel_y     (pix_y),
      .flags       (flags)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (advance && flags.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && flags.emit) begin
         out_x_ff      <= pix_x;
         out_y_ff      <= pix_y;
         out_inside_ff <= flags.in_window;
         out_last_ff   <= flags.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_BITS-2*COORD_BITS){1'b0}}, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_inside_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hw/rtl/lps_checker.sv =====
module lps_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                              rsp_tuser
);

   // a stalled response keeps its pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // the only back pressure on requests is a waiting response
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled with response side free");

   // an inside pixel never has a negative coordinate
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         !rsp_tdata[COORD_BITS-1] && !rsp_tdata[2*COORD_BITS-1])
      else $error("inside flag on negative coordinate");

endmodule

bind line_pixel_stepper_top lps_checker #(
   .COORD_BITS(COORD_BITS)
) u_lps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/line_pixel_checker.sv =====
module line_pixel_checker
   import lps_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,  // start_x, start_y, end_x_in, end_y_in
   input  logic                              req_tuser,  // mode
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,  // pixel_x, pixel_y
   input  logic                              rsp_tuser,  // inside_res
   input  logic                              rsp_tlast,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [CLIP_BITS-1:0]              csr_data,
   output int                                mismatches,
   output int                                pending
);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      in_window;
      logic      last;
   } pixel_type;

   coord_type                   cur_x, cur_y, goal_x, goal_y;
   logic [COORD_BITS-1:0]       delta_x, delta_y;
   logic                        step_x_neg, step_y_neg;
   logic signed [COORD_BITS+1:0] err_acc;
   logic                        line_on;
   logic [CLIP_BITS-1:0]        clip_w, clip_h;
   pixel_type                   expected_pixels[$];

   initial mismatches = 0;
   initial pending = 0;

   function automatic bit trace_line_item(input logic mode,
                                          input logic [((4*COORD_BITS+7)/8)*8-1:0] data,
                                          output pixel_type px);
      coord_type x0, y0, x1, y1;
      int ix0, iy0, ix1, iy1, dx, dy, e2;
      px = '0;
      x0 = data[0 +: COORD_BITS];
      y0 = data[COORD_BITS +: COORD_BITS];
      x1 = data[2*COORD_BITS +: COORD_BITS];
      y1 = data[3*COORD_BITS +: COORD_BITS];
      if (mode == MODE_LOAD) begin
         ix0 = x0;
         iy0 = y0;
         ix1 = x1;
         iy1 = y1;
         dx = (ix0 > ix1) ? ix0 - ix1 : ix1 - ix0;
         dy = (iy0 > iy1) ? iy0 - iy1 : iy1 - iy0;
         cur_x = x0;
         cur_y = y0;
         goal_x = x1;
         goal_y = y1;
         delta_x = dx[COORD_BITS-1:0];
         delta_y = dy[COORD_BITS-1:0];
         step_x_neg = !(ix0 < ix1);
         step_y_neg = !(iy0 < iy1);
         err_acc = dx - dy;
         line_on = 1'b1;
         return 1'b0;
      end
      if (!line_on)
         return 1'b0;
      ix0 = cur_x;
      iy0 = cur_y;
      px.x = cur_x;
      px.y = cur_y;
      px.in_window = ix0 >= 0 && ix0 < int'(clip_w) && iy0 >= 0 && iy0 < int'(clip_h);
      px.last = (cur_x == goal_x) && (cur_y == goal_y);
      if (px.last) begin
         line_on = 1'b0;
      end else begin
         dx = delta_x;
         dy = delta_y;
         e2 = 2 * int'(err_acc);
         if (e2 > -dy) begin
            err_acc = int'(err_acc) - dy;
            cur_x = step_x_neg ? cur_x - 1 : cur_x + 1;
         end
         if (e2 < dx) begin
            err_acc = int'(err_acc) + dx;
            cur_y = step_y_neg ? cur_y - 1 : cur_y + 1;
         end
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      pixel_type want, got;
      bit        emits;
      if (reset) begin
         clip_w = CLIP_WIDTH_RESET;
         clip_h = CLIP_HEIGHT_RESET;
         cur_x = '0;
         cur_y = '0;
         goal_x = '0;
         goal_y = '0;
         delta_x = '0;
         delta_y = '0;
         step_x_neg = 1'b0;
         step_y_neg = 1'b0;
         err_acc = '0;
         line_on = 1'b0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CLIP_WIDTH)
               clip_w = csr_data;
            else if (csr_index == CSR_CLIP_HEIGHT)
               clip_h = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.x = rsp_tdata[0 +: COORD_BITS];
            got.y = rsp_tdata[COORD_BITS +: COORD_BITS];
            got.in_window = rsp_tuser;
            got.last = rsp_tlast;
            if (expected_pixels.size() == 0) begin
               $error("pixel transfer with none expected: x %0d y %0d", got.x, got.y);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.x !== want.x) begin
                  $error("pixel_x expected %0d got %0d", want.x, got.x);
                  mismatches++;
               end
               if (got.y !== want.y) begin
                  $error("pixel_y expected %0d got %0d", want.y, got.y);
                  mismatches++;
               end
               if (got.in_window !== want.in_window) begin
                  $error("inside_res expected %0d got %0d", want.in_window, got.in_window);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, got.last);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            emits = trace_line_item(req_tuser, req_tdata, want);
            if (emits)
               expected_pixels = {expected_pixels, want};
         end
      end
      pending <= expected_pixels.size();
   end

endmodule

// ===== tb/line_pixel_stepper_top_tb.sv =====
module line_pixel_stepper_top_tb;
   import lps_pkg::*;

   localparam int COORD_BITS = 12;
   localparam int REQ_W = ((4*COORD_BITS+7)/8)*8;
   localparam int RSP_W = ((2*COORD_BITS+7)/8)*8;
   localparam int COORD_SPAN = 1 << COORD_BITS;
   localparam int COORD_MIN = -(COORD_SPAN / 2);
   localparam int COORD_MAX = COORD_SPAN / 2 - 1;
   localparam int CLIP_MAX = (1 << CLIP_BITS) - 1;
   localparam int CSR_FIRST_UNUSED = int'(CSR_CLIP_HEIGHT) + 1;
   localparam int CSR_LAST = (1 << CSR_INDEX_BITS) - 1;
   localparam int MAX_GAP = 17;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASE_ITEMS = 100;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata = '0;
   logic                      req_tuser = MODE_STEP;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_W-1:0]          rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CLIP_BITS-1:0]      csr_data = '0;

   int mismatch_count;
   int pixels_pending;
   int idle_cycles = 0;
   int clip_w_now = CLIP_WIDTH_RESET;
   int clip_h_now = CLIP_HEIGHT_RESET;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   line_pixel_stepper_top #(.COORD_BITS(COORD_BITS)) dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   line_pixel_checker #(.COORD_BITS(COORD_BITS)) pixel_check (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatches(mismatch_count), .pending(pixels_pending)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("line_pixel_stepper_top_tb NOT OK");
         $finish;
      end
   end

   function automatic int draw_gap(input bit burst);
      return burst ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   function automatic int clamp_coord(input int v);
      return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
   endfunction

   // receiver: random stalls, one long hold-off while the sender keeps going
   initial begin
      int stall;
      forever begin
         if ($urandom_range(0, 24) == 0)
            rsp_burst = !rsp_burst;
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = draw_gap(rsp_burst);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic push_req(input logic mode, input logic [REQ_W-1:0] data);
      int gap;
      if ($urandom_range(0, 24) == 0)
         req_burst = !req_burst;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_line(input int x0, input int y0, input int x1, input int y1);
      logic [REQ_W-1:0] data;
      data = '0;
      data[0 +: COORD_BITS] = x0[COORD_BITS-1:0];
      data[COORD_BITS +: COORD_BITS] = y0[COORD_BITS-1:0];
      data[2*COORD_BITS +: COORD_BITS] = x1[COORD_BITS-1:0];
      data[3*COORD_BITS +: COORD_BITS] = y1[COORD_BITS-1:0];
      push_req(MODE_LOAD, data);
   endtask

   task automatic step_n(input int n);
      repeat (n) push_req(MODE_STEP, REQ_W'({$urandom, $urandom}));
   endtask

   task automatic csr_put(input logic [CSR_INDEX_BITS-1:0] idx,
                          input logic [CLIP_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_clip(input int w, input int h);
      // unused index first, must leave the window alone
      csr_put(CSR_INDEX_BITS'($urandom_range(CSR_FIRST_UNUSED, CSR_LAST)),
              CLIP_BITS'($urandom));
      csr_put(CSR_CLIP_WIDTH, CLIP_BITS'(w));
      csr_put(CSR_CLIP_HEIGHT, CLIP_BITS'(h));
      csr_valid <= 1'b0;
      clip_w_now = w;
      clip_h_now = h;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pixels_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_line(output int x0, output int y0, output int x1, output int y1,
                              output int span);
      int r, reach, ax, ay;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         x0 = int'($urandom_range(0, COORD_SPAN - 1)) + COORD_MIN;
         y0 = int'($urandom_range(0, COORD_SPAN - 1)) + COORD_MIN;
         x1 = int'($urandom_range(0, COORD_SPAN - 1)) + COORD_MIN;
         y1 = int'($urandom_range(0, COORD_SPAN - 1)) + COORD_MIN;
      end else begin
         reach = (r < 3) ? 60 : 12;
         x0 = int'($urandom_range(0, clip_w_now + 40)) - 20;
         y0 = int'($urandom_range(0, clip_h_now + 40)) - 20;
         x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * reach)) - reach);
         y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * reach)) - reach);
      end
      ax = (x1 > x0) ? x1 - x0 : x0 - x1;
      ay = (y1 > y0) ? y1 - y0 : y0 - y1;
      span = ((ax > ay) ? ax : ay) + 1;
   endtask

   // mostly complete lines, some cut short by a reload, some idle steps after the end
   task automatic random_lines(input int items);
      int done, kind, x0, y0, x1, y1, span, steps;
      done = 0;
      while (done < items) begin
         kind = $urandom_range(0, 99);
         random_line(x0, y0, x1, y1, span);
         load_line(x0, y0, x1, y1);
         if (span > 200)
            steps = $urandom_range(1, 24);
         else if (kind < 80)
            steps = span + (($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 2)) : 0);
         else
            steps = $urandom_range(0, span - 1);
         step_n(steps);
         done += 1 + steps;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      step_n(1);
      load_line(5, 5, 5, 5);
      step_n(2);
      load_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      step_n(2);
      load_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      step_n(2);
      load_line(COORD_MAX - 2, COORD_MAX, COORD_MAX, COORD_MAX - 3);
      step_n(4);
      load_line(799, 599, 800, 600);
      step_n(2);
      load_line(1, 0, -1, 0);
      step_n(3);
      settle();

      set_clip(CLIP_MAX, CLIP_MAX);
      random_lines(PHASE_ITEMS);
      settle();

      set_clip(1, 1);
      hold_go = 1'b1;
      random_lines(PHASE_ITEMS);
      settle();

      set_clip(0, 0);
      random_lines(PHASE_ITEMS / 2);
      settle();

      set_clip($urandom_range(1, CLIP_MAX), $urandom_range(1, CLIP_MAX));
      random_lines(PHASE_ITEMS);
      settle();

      set_clip($urandom_range(1, 64), $urandom_range(1, 64));
      random_lines(PHASE_ITEMS);
      settle();

      if (mismatch_count == 0)
         $display("line_pixel_stepper_top_tb OK");
      else
         $display("line_pixel_stepper_top_tb NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lps_pkg.sv
hw/rtl/lps_line_core.sv
hw/rtl/line_pixel_stepper_top.sv
hw/rtl/lps_checker.sv
tb/line_pixel_checker.sv
tb/line_pixel_stepper_top_tb.sv
